/* hdl/cbq_pkg.sv */
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and constants for the cascaded biquad equalizer.
// ----------------------------------------------------------------------------
package cbq_pkg;

    localparam int NCOEF = 5;
    localparam logic signed [31:0] COEF_ONE = 32'sd268435456;

    // coefficient codes
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // beat handed from one cell to the next
    typedef struct packed {
        logic               vld;
        logic               wr;      // coefficient write
        logic               filt;    // filter this sample
        logic [2:0]         band;
        logic [2:0]         coef;
        logic signed [31:0] data;    // signal (Q8.23) or coefficient (Q3.28)
        logic [2:0]         chan;
        logic signed [15:0] raw;
    } cbq_beat_t;

    // floor(k * s / 2^28) for one product
    function automatic logic signed [35:0] mul_q28(input logic signed [31:0] k,
                                                   input logic signed [31:0] s);
        logic signed [63:0] p;
        p = k * s;
        return p[63:28];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        if (v > 39'sd2147483647) return 32'sh7fffffff;
        if (v < -39'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

/* hdl/cbq_cell.sv */
// ----------------------------------------------------------------------------
// cbq_cell
// One biquad section: own coefficients, per-channel history, two stages.
// ----------------------------------------------------------------------------
module cbq_cell #(
    parameter int CHANNELS = 2,
    parameter int BAND_ID  = 0,
    parameter int CW       = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  cbq_pkg::cbq_beat_t in_beat,
    output cbq_pkg::cbq_beat_t out_beat
);
    logic signed [31:0] k_reg [cbq_pkg::NCOEF];
    logic signed [31:0] x1_reg [CHANNELS];
    logic signed [31:0] x2_reg [CHANNELS];
    logic signed [31:0] y1_reg [CHANNELS];
    logic signed [31:0] y2_reg [CHANNELS];
    logic signed [35:0] p_reg [cbq_pkg::NCOEF];
    cbq_pkg::cbq_beat_t mid_reg;
    cbq_pkg::cbq_beat_t out_reg;
    cbq_pkg::cbq_beat_t out_next;
    logic signed [38:0] acc;
    logic signed [31:0] y_sat;
    logic [CW-1:0] ch;
    logic [CW-1:0] mch;
    logic hit;

    assign ch  = in_beat.chan[CW-1:0];
    assign mch = mid_reg.chan[CW-1:0];
    assign hit = in_beat.wr && (in_beat.band == 3'(BAND_ID));

    always_comb begin
        acc = 39'(p_reg[0]) + 39'(p_reg[1]) + 39'(p_reg[2])
            - 39'(p_reg[3]) - 39'(p_reg[4]);
        y_sat = cbq_pkg::sat32(acc);
        out_next = mid_reg;
        if (mid_reg.vld && mid_reg.filt) out_next.data = y_sat;
    end

    // stage one: multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg.vld <= 1'b0;
            for (int i = 0; i < cbq_pkg::NCOEF; i++)
                k_reg[i] <= (i == 0) ? cbq_pkg::COEF_ONE : '0;
            for (int c = 0; c < CHANNELS; c++) begin
                x1_reg[c] <= '0;
                x2_reg[c] <= '0;
            end
        end else if (adv) begin
            mid_reg <= in_beat;
            if (in_beat.vld && hit) begin
                k_reg[in_beat.coef] <= in_beat.data;
                for (int c = 0; c < CHANNELS; c++) begin
                    x1_reg[c] <= '0;
                    x2_reg[c] <= '0;
                end
            end
            if (in_beat.vld && in_beat.filt) begin
                p_reg[0] <= cbq_pkg::mul_q28(k_reg[0], in_beat.data);
                p_reg[1] <= cbq_pkg::mul_q28(k_reg[1], x1_reg[ch]);
                p_reg[2] <= cbq_pkg::mul_q28(k_reg[2], x2_reg[ch]);
                p_reg[3] <= cbq_pkg::mul_q28(k_reg[3], y1_reg[ch]);
                p_reg[4] <= cbq_pkg::mul_q28(k_reg[4], y2_reg[ch]);
                x2_reg[ch] <= x1_reg[ch];
                x1_reg[ch] <= in_beat.data;
            end
        end
    end

    // stage two: sum, saturate, update output history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                y1_reg[c] <= '0;
                y2_reg[c] <= '0;
            end
        end else if (adv) begin
            out_reg <= out_next;
            if (mid_reg.vld && mid_reg.wr && mid_reg.band == 3'(BAND_ID)) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    y1_reg[c] <= '0;
                    y2_reg[c] <= '0;
                end
            end
            if (mid_reg.vld && mid_reg.filt) begin
                y2_reg[mch] <= y1_reg[mch];
                y1_reg[mch] <= y_sat;
            end
        end
    end

    assign out_beat = out_reg;
endmodule

/* hdl/cascaded_biquad_equalizer.sv */
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer
// Multi-channel audio equalizer built as a cascade of biquad cells.
// ----------------------------------------------------------------------------
// Each beat on the s_ channel is either a sample or a coefficient write. The
// beat walks down a row of BANDS biquad cells, two stages per cell (one for
// the five products, one for the sum and saturation), and the first stage
// loads at the accept edge; the last cell feeds the output register through
// the clamp and scale, and a sample beat that leaves it raises m_valid. One
// beat is in flight at a time: the next beat is accepted only once the busy
// count has covered the walk through the cell row, and a result that waits
// for m_ready holds s_ready low until it is taken. Coefficient writes give
// no result and clear that band's history in all channels; writes aimed
// outside the bank are dropped and give no result either. Samples bypass
// unchanged when eq_enabled is low or the channel is out of range.
module cascaded_biquad_equalizer #(
    parameter int BANDS    = 5,
    parameter int CHANNELS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic               s_channel,
    input  logic signed [15:0] s_sample_in,
    input  logic [2:0]         s_band_select,
    input  logic [2:0]         s_coef_select,
    input  logic signed [31:0] s_coef_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_channel_out,
    output logic signed [15:0] m_sample_out
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = 2 * BANDS + 1;
    localparam int DW = $clog2(DEPTH + 1);

    cbq_pkg::cbq_beat_t chain [BANDS+1];
    cbq_pkg::cbq_beat_t head;
    logic en_reg;
    logic busy_reg, busy_next;
    logic [DW-1:0] cnt_reg, cnt_next;
    logic ovld_reg;
    logic och_reg;
    logic signed [15:0] osmp_reg;
    logic adv;
    logic s_acc;
    logic signed [31:0] vclamp;
    logic signed [47:0] vscaled;
    logic signed [47:0] vq;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) en_reg <= 1'b1;
        else if (cfg_valid && cfg_ready) en_reg <= cfg_data;
    end

    // accept only when the row is empty and the output register is free
    assign s_ready = !busy_reg && !ovld_reg;
    assign s_acc = s_valid && s_ready;
    assign adv = 1'b1;

    always_comb begin
        head.vld  = s_acc;
        head.wr   = (s_command == cbq_pkg::CMD_COEF) && (32'(s_band_select) < BANDS)
                    && (s_coef_select <= cbq_pkg::COEF_A2);
        head.filt = (s_command == cbq_pkg::CMD_SAMPLE) && en_reg
                    && (32'(s_channel) < CHANNELS);
        head.band = s_band_select;
        head.coef = s_coef_select;
        head.data = (s_command == cbq_pkg::CMD_COEF) ? s_coef_value
                    : {{8{s_sample_in[15]}}, s_sample_in, 8'd0};
        head.chan = 3'(s_channel);
        head.raw  = s_sample_in;
        // drop a write aimed outside the bank: nothing lands, nothing comes out
        if (s_command == cbq_pkg::CMD_COEF && !head.wr) head.vld = 1'b0;
    end
    assign chain[0] = head;

    for (genvar b = 0; b < BANDS; b++) begin : g_band
        cbq_cell #(.CHANNELS(CHANNELS), .BAND_ID(b), .CW(CW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_beat(chain[b]), .out_beat(chain[b+1])
        );
    end

    // track the beat in flight
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (s_acc) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DW'(DEPTH - 1)) busy_next = 1'b0;
        end
    end

    // clamp to +-1.0, scale by 32767, truncate toward zero
    always_comb begin
        vclamp = chain[BANDS].data;
        if (vclamp > 32'sd8388608) vclamp = 32'sd8388608;
        if (vclamp < -32'sd8388608) vclamp = -32'sd8388608;
        vscaled = 48'(vclamp) * 48'sd32767;
        if (vscaled < 0) vq = -((-vscaled) >>> 23);
        else vq = vscaled >>> 23;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            ovld_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (ovld_reg && m_ready) ovld_reg <= 1'b0;
            // only a sample beat leaving the row carries a result
            if (chain[BANDS].vld && !chain[BANDS].wr) ovld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (chain[BANDS].vld) begin
            och_reg  <= chain[BANDS].chan[0];
            osmp_reg <= chain[BANDS].filt ? vq[15:0] : chain[BANDS].raw;
        end
    end

    assign m_valid       = ovld_reg;
    assign m_channel_out = och_reg;
    assign m_sample_out  = osmp_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovld_reg && !m_ready) |=> ovld_reg) else $error("result lost");
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> busy_reg) else $error("beat not tracked");
endmodule

/* dv/cascaded_biquad_equalizer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer_test
// Self-checking bench: a directed table of samples and coefficient writes,
// then randomized traffic. It runs with and without bypass, random sender
// bursts and receiver stalls. Every result is checked against a bit-true
// filter predictor, or against a sample typed in by hand where a row has one.
// ----------------------------------------------------------------------------
module cascaded_biquad_equalizer_test;

    localparam int BANDS    = 5;
    localparam int CHANNELS = 2;
    localparam int LATENCY  = 2 * BANDS + 2;
    localparam int N_RANDOM = 880;
    localparam logic CMD_S  = cbq_pkg::CMD_SAMPLE;
    localparam logic CMD_W  = cbq_pkg::CMD_COEF;

    typedef struct {
        bit                 en;      // eq_enabled for this row
        logic               cmd;
        logic               chan;
        logic signed [15:0] smp;
        logic [2:0]         band;
        logic [2:0]         coef;
        logic signed [31:0] val;
        bit                 typed;   // expected sample typed in by hand
        logic signed [15:0] want;
    } eq_item_t;

    typedef struct {
        logic               chan;
        logic signed [15:0] smp;
    } eq_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_command = cbq_pkg::CMD_SAMPLE;
    logic               s_channel = 1'b0;
    logic signed [15:0] s_sample_in = '0;
    logic [2:0]         s_band_select = '0;
    logic [2:0]         s_coef_select = '0;
    logic signed [31:0] s_coef_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_channel_out;
    logic signed [15:0] m_sample_out;

    // predictor state: its own copy of the filter
    bit                 eq_on;
    logic signed [31:0] coef_mem [BANDS*cbq_pkg::NCOEF];
    logic signed [31:0] x_hist [CHANNELS*BANDS*2];
    logic signed [31:0] y_hist [CHANNELS*BANDS*2];

    eq_result_t pending_outputs[$];
    eq_item_t   stim_table[$];
    int         mismatches = 0;
    int         burst_left = 0;
    int unsigned cycle_count = 0;

    cascaded_biquad_equalizer #(.BANDS(BANDS), .CHANNELS(CHANNELS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_channel(s_channel), .s_sample_in(s_sample_in),
        .s_band_select(s_band_select), .s_coef_select(s_coef_select),
        .s_coef_value(s_coef_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_channel_out(m_channel_out), .m_sample_out(m_sample_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run one accepted beat through the filter model; return 1 if it yields a result.
    function automatic bit eq_filter(input eq_item_t it, output logic signed [15:0] res);
        longint v, acc, y;
        int     h, k;
        res = it.smp;
        if (it.cmd == cbq_pkg::CMD_COEF) begin
            // drop writes aimed outside the bank
            if (it.band >= BANDS || it.coef >= cbq_pkg::NCOEF) return 1'b0;
            coef_mem[it.band*cbq_pkg::NCOEF + it.coef] = it.val;
            for (int c = 0; c < CHANNELS; c++) begin
                h = (c*BANDS + it.band) * 2;
                x_hist[h] = '0; x_hist[h+1] = '0;
                y_hist[h] = '0; y_hist[h+1] = '0;
            end
            return 1'b0;
        end
        if (!eq_on || it.chan >= CHANNELS) return 1'b1;
        v = longint'(it.smp) * 256;
        for (int b = 0; b < BANDS; b++) begin
            k = b * cbq_pkg::NCOEF;
            h = (int'(it.chan)*BANDS + b) * 2;
            // each product floored to 23 fractional bits
            acc = ((longint'(coef_mem[k+cbq_pkg::COEF_B0]) * v) >>> 28)
                + ((longint'(coef_mem[k+cbq_pkg::COEF_B1]) * longint'(x_hist[h])) >>> 28)
                + ((longint'(coef_mem[k+cbq_pkg::COEF_B2]) * longint'(x_hist[h+1])) >>> 28)
                - ((longint'(coef_mem[k+cbq_pkg::COEF_A1]) * longint'(y_hist[h])) >>> 28)
                - ((longint'(coef_mem[k+cbq_pkg::COEF_A2]) * longint'(y_hist[h+1])) >>> 28);
            y = acc > 64'sd2147483647 ? 64'sd2147483647 :
                acc < -64'sd2147483648 ? -64'sd2147483648 : acc;
            x_hist[h+1] = x_hist[h];
            x_hist[h]   = v[31:0];
            y_hist[h+1] = y_hist[h];
            y_hist[h]   = y[31:0];
            v = y;
        end
        if (v > 8388608) v = 8388608;
        if (v < -8388608) v = -8388608;
        v = (v * 32767) / 8388608;   // signed divide truncates toward zero
        res = v[15:0];
        return 1'b1;
    endfunction

    // Write eq_enabled once the filter has drained.
    task automatic write_enable(input bit en);
        wait (pending_outputs.size() == 0);
        repeat (LATENCY + 8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        eq_on = en;
    endtask

    // Present one beat, hold it until accepted, then update the prediction.
    task automatic send_beat(input eq_item_t it);
        eq_result_t r;
        logic signed [15:0] res;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_command     <= it.cmd;
        s_channel     <= it.chan;
        s_sample_in   <= it.smp;
        s_band_select <= it.band;
        s_coef_select <= it.coef;
        s_coef_value  <= it.val;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (eq_filter(it, res)) begin
            r.chan = it.chan;
            r.smp  = it.typed ? it.want : res;
            pending_outputs.push_back(r);
        end
    endtask

    function automatic eq_item_t row(input bit en, input logic cmd, input logic ch,
                                     input logic signed [15:0] smp,
                                     input logic [2:0] band, input logic [2:0] coef,
                                     input logic [31:0] val, input bit typed,
                                     input logic signed [15:0] want);
        eq_item_t it;
        it.en = en; it.cmd = cmd; it.chan = ch; it.smp = smp;
        it.band = band; it.coef = coef; it.val = val;
        it.typed = typed; it.want = want;
        return it;
    endfunction

    function automatic eq_item_t random_beat(input bit en);
        eq_item_t it;
        it = row(en, CMD_S, 1'($urandom_range(0, 1)), 16'sd0, 3'd0, 3'd0, 32'h0,
                 1'b0, 16'sd0);
        case ($urandom_range(0, 9))
            0: it.smp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2: it.smp = 16'($urandom_range(0, 512) - 256);
            default: it.smp = 16'($urandom);
        endcase
        it.band = 3'($urandom_range(0, 7));
        it.coef = 3'($urandom_range(0, 7));
        it.val  = $urandom;
        if ($urandom_range(0, 99) < 14) begin
            it.cmd = CMD_W;
            // mostly legal targets with tame values so the cascade stays alive
            if ($urandom_range(0, 9) != 0) begin
                it.band = 3'($urandom_range(0, BANDS - 1));
                it.coef = 3'($urandom_range(0, cbq_pkg::NCOEF - 1));
            end
            if ($urandom_range(0, 3) != 0)
                it.val = (it.coef == cbq_pkg::COEF_B0 ? cbq_pkg::COEF_ONE : 32'sd0)
                       + $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        end
        return it;
    endfunction

    // Receiver: stall on a pattern that steps through four modes in turn.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count >> 7) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (cycle_count[2:0] != 3'd0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every result beat against the oldest expectation.
    always @(posedge aclk) begin
        eq_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: chan %0d sample %0d",
                             m_channel_out, m_sample_out);
            end else begin
                e = pending_outputs.pop_front();
                if (m_channel_out !== e.chan || m_sample_out !== e.smp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected chan %0d sample %0d, got chan %0d sample %0d",
                                 e.chan, e.smp, m_channel_out, m_sample_out);
                end
            end
        end
    end

    initial begin
        // directed: reset coefficients pass x*32767/32768, then real filters
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, 16'sd0, 3'd0, 3'd0, 32'h0,
                                 1'b1, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, 16'sd32767, 3'd0, 3'd0, 32'h0,
                                 1'b1, 16'sd32766));
        stim_table.push_back(row(1'b1, CMD_S, 1'b1, 16'sh8000, 3'd0, 3'd0, 32'h0,
                                 1'b1, -16'sd32767));
        stim_table.push_back(row(1'b1, CMD_S, 1'b1, 16'sd1, 3'd0, 3'd0, 32'h0,
                                 1'b1, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, -16'sd1, 3'd0, 3'd0, 32'h0,
                                 1'b1, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd0, cbq_pkg::COEF_B0,
                                 32'h7fff_ffff, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, 16'sh8000, 3'd0, 3'd0, 32'h0,
                                 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b1, 16'sd32767, 3'd0, 3'd0, 32'h0,
                                 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd0, cbq_pkg::COEF_B0,
                                 32'h8000_0000, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, 16'sd32767, 3'd0, 3'd0, 32'h0,
                                 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd0, cbq_pkg::COEF_B0,
                                 cbq_pkg::COEF_ONE, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd1, cbq_pkg::COEF_B1,
                                 32'h0800_0000, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd1, cbq_pkg::COEF_B2,
                                 32'hf800_0000, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd2, cbq_pkg::COEF_A1,
                                 32'he000_0000, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd4, cbq_pkg::COEF_A2,
                                 32'h0400_0000, 1'b0, 16'sd0));
        // writes outside the bank are ignored
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd5, cbq_pkg::COEF_B0,
                                 32'h1234_5678, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd7, 3'd7,
                                 32'hffff_ffff, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_W, 1'b0, 16'sd0, 3'd0, 3'd5,
                                 32'h0000_0000, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, 16'sd20000, 3'd0, 3'd0, 32'h0,
                                 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b1, -16'sd20000, 3'd0, 3'd0, 32'h0,
                                 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, 16'sd12345, 3'd0, 3'd0, 32'h0,
                                 1'b0, 16'sd0));
        stim_table.push_back(row(1'b1, CMD_S, 1'b0, 16'sh8000, 3'd0, 3'd0, 32'h0,
                                 1'b0, 16'sd0));
        // bypass: samples pass straight through, writes still land
        stim_table.push_back(row(1'b0, CMD_S, 1'b0, 16'sd32767, 3'd0, 3'd0, 32'h0,
                                 1'b1, 16'sd32767));
        stim_table.push_back(row(1'b0, CMD_S, 1'b1, 16'sh8000, 3'd0, 3'd0, 32'h0,
                                 1'b1, 16'sh8000));
        stim_table.push_back(row(1'b0, CMD_W, 1'b0, 16'sd0, 3'd3, cbq_pkg::COEF_B0,
                                 32'h0c00_0000, 1'b0, 16'sd0));
        stim_table.push_back(row(1'b0, CMD_S, 1'b0, 16'sd5, 3'd0, 3'd0, 32'h0,
                                 1'b1, 16'sd5));
        // random: enabled, bypassed, enabled again
        for (int i = 0; i < N_RANDOM; i++)
            stim_table.push_back(random_beat(!(i >= 400 && i < 500)));
    end

    initial begin
        // reset state of the predictor
        eq_on = 1'b1;
        for (int i = 0; i < BANDS*cbq_pkg::NCOEF; i++)
            coef_mem[i] = (i % cbq_pkg::NCOEF == 0) ? cbq_pkg::COEF_ONE : 32'sd0;
        for (int i = 0; i < CHANNELS*BANDS*2; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_enable(1'b1);
        foreach (stim_table[i]) begin
            if (stim_table[i].en != eq_on) begin
                s_valid <= 1'b0;
                write_enable(stim_table[i].en);
            end
            send_beat(stim_table[i]);
        end
        s_valid <= 1'b0;
        wait (pending_outputs.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* cascaded_biquad_equalizer.f */
hdl/cbq_pkg.sv
hdl/cbq_cell.sv
hdl/cascaded_biquad_equalizer.sv
dv/cascaded_biquad_equalizer_test.sv
